// ===== rtl/core/deadline_sorted_timer_queue_assert.svh =====
// assertion helpers for the timer queue
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication, off during reset
`define DSTQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue check failed");

// next-cycle implication, off during reset
`define DSTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue check failed");

`endif

// ===== rtl/core/dstq_pkg.sv =====
package dstq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int TIME_W        = 32;
  localparam int DUR_W         = 16;
  localparam int TAG_W         = 8;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic STATUS_EXPIRED  = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_TICK
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] key;
    logic [TAG_W-1:0]  tag;
  } cell_ctl_t;

endpackage

// ===== rtl/core/dstq_cell.sv =====
module dstq_cell (
  input  logic               clk,
  input  logic               rst,
  input  dstq_pkg::cell_ctl_t ctl,
  input  dstq_pkg::entry_t   left,
  input  dstq_pkg::entry_t   right,
  input  logic               found_in,
  output dstq_pkg::entry_t   ent,
  output logic               found_out,
  output logic               later
);
  import dstq_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] deadline;
  logic [TAG_W-1:0]  tag;
  logic [TIME_W-1:0] diff;
  logic              take_new;
  entry_t            ent_next;

  assign ent = '{valid: valid, deadline: deadline, tag: tag};

  // stored deadline is strictly later than the key, wrap-aware
  assign diff      = ctl.key - deadline;
  assign later     = diff[TIME_W-1];
  assign take_new  = !valid || later;
  assign found_out = found_in || take_new;

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      OP_HOLD: ent_next = ent;
      OP_INSERT: begin
        // cells past the insert point move one place back
        if (found_in) begin
          ent_next = left;
        end else if (take_new) begin
          ent_next = '{valid: 1'b1, deadline: ctl.key, tag: ctl.tag};
        end
      end
      OP_SHIFT: ent_next = right;
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= ent_next.deadline;
    tag      <= ent_next.tag;
  end

endmodule

// ===== rtl/core/deadline_sorted_timer_queue.sv =====
// add: busy in the S_ADD state after the accept edge while the cell row inserts in one pass
// full add: rejected with one result on the cycle after accept, never busy
// tick: k expiries leave one per cycle from the head cell, each through the S_TICK state
//   and the result registers; busy while in S_TICK, at most MAX_RESULTS
// synchronous reset clears the seconds count and all cell valid bits
// results cannot be stalled: each is on the ports for exactly one cycle
module deadline_sorted_timer_queue #(
  parameter int QUEUE_DEPTH = dstq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [dstq_pkg::DUR_W-1:0]  duration,
  input  logic [dstq_pkg::TAG_W-1:0]  tag,
  output logic                        strobe,
  output logic                        status,
  output logic [dstq_pkg::TAG_W-1:0]  out_tag,
  output logic                        last
);
  import dstq_pkg::*;

  localparam int CntW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  state_t            state, state_next;
  logic [TIME_W-1:0] now_sec;
  logic [TIME_W-1:0] add_deadline;
  logic [TAG_W-1:0]  add_tag;
  logic [CntW-1:0]   emit_cnt;

  cell_ctl_t         ctl;
  entry_t            ent   [QUEUE_DEPTH];
  entry_t            left  [QUEUE_DEPTH];
  entry_t            right [QUEUE_DEPTH];
  logic              found [QUEUE_DEPTH+1];
  logic              later [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_vec;

  logic accept, full, head_due, next_due, emit, emit_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = ent[QUEUE_DEPTH-1].valid;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i] = '0;
    end else begin : g_mid
      assign left[i] = ent[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_body
      assign right[i] = ent[i+1];
    end
    assign valid_vec[i] = ent[i].valid;

    dstq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (left[i]),
      .right     (right[i]),
      .found_in  (found[i]),
      .ent       (ent[i]),
      .found_out (found[i+1]),
      .later     (later[i])
    );
  end

  // during a tick the key is the current second, so !later means due
  assign head_due  = ent[0].valid && !later[0];
  assign next_due  = ent[1].valid && !later[1];
  assign emit_last = (emit_cnt == CntW'(MAX_RESULTS - 1)) || !next_due;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && mode == MODE_TICK) begin
          state_next = S_TICK;
        end else if (accept && !full) begin
          state_next = S_ADD;
        end
      end
      S_ADD: state_next = S_IDLE;
      S_TICK: begin
        if (!head_due || emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '{op: OP_HOLD, key: now_sec, tag: add_tag};
    emit = 1'b0;
    unique case (state)
      S_IDLE: ctl.op = OP_HOLD;
      S_ADD: begin
        ctl.op  = OP_INSERT;
        ctl.key = add_deadline;
      end
      S_TICK: begin
        emit = head_due;
        if (head_due) begin
          ctl.op = OP_SHIFT;
        end
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      now_sec  <= '0;
      emit_cnt <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit || (accept && mode == MODE_ADD && full);
      if (accept && mode == MODE_TICK) begin
        now_sec  <= now_sec + TIME_W'(1);
        emit_cnt <= '0;
      end else if (emit) begin
        emit_cnt <= emit_cnt + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      add_deadline <= now_sec + TIME_W'(duration);
      add_tag      <= tag;
    end
    if (emit) begin
      status  <= STATUS_EXPIRED;
      out_tag <= ent[0].tag;
      last    <= emit_last;
    end else if (accept && mode == MODE_ADD && full) begin
      status  <= STATUS_REJECTED;
      out_tag <= tag;
      last    <= 1'b1;
    end
  end

`include "deadline_sorted_timer_queue_assert.svh"

  `DSTQ_ASSERT_IMP(a_valid_prefix, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
  `DSTQ_ASSERT_IMP(a_reject_last, strobe && status == STATUS_REJECTED, last)
  `DSTQ_ASSERT_IMP(a_more_pending, strobe && status == STATUS_EXPIRED && !last, state == S_TICK)
  `DSTQ_ASSERT_NEXT(a_add_done, state == S_ADD, state == S_IDLE && !strobe)

endmodule

// ===== bench/tb_deadline_sorted_timer_queue.sv =====
module tb_deadline_sorted_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import dstq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_BEATS = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic             op;
    logic [DUR_W-1:0] dur;
    logic [TAG_W-1:0] tg;
    logic [6:0]       idle_pct;
  } timer_beat_t;

  typedef struct packed {
    logic             status;
    logic [TAG_W-1:0] tg;
    logic             last;
  } expiry_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             mode = MODE_ADD;
  logic [DUR_W-1:0] duration = '0;
  logic [TAG_W-1:0] tag = '0;
  logic             strobe;
  logic             status;
  logic [TAG_W-1:0] out_tag;
  logic             last;

  timer_beat_t pending_beats[$];
  expiry_t     expected_expiries[$];

  // shadow of the timer queue, kept sorted with slot 0 the head
  logic [TIME_W-1:0] sec_count = '0;
  logic [TIME_W-1:0] sched_deadline[DEPTH];
  logic [TAG_W-1:0]  sched_tag[DEPTH];
  int                sched_cnt = 0;

  int mismatches  = 0;
  int beats_total = 0;
  int beats_taken = 0;
  int cycles      = 0;
  bit beat_taken  = 1'b0;

  deadline_sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .duration (duration),
    .tag      (tag),
    .strobe   (strobe),
    .status   (status),
    .out_tag  (out_tag),
    .last     (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_later(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = b - a;
    return d[TIME_W-1];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic queue_beat(input logic op, input int dur, input int tg, input int idle_pct);
    timer_beat_t b;
    b.op       = op;
    b.dur      = DUR_W'(dur);
    b.tg       = TAG_W'(tg);
    b.idle_pct = 7'(idle_pct);
    pending_beats.push_back(b);
    beats_total++;
  endtask

  // updates the shadow queue for one accepted beat and records the expiries it causes
  task automatic apply_timer_beat(input logic op, input logic [DUR_W-1:0] dur,
                                  input logic [TAG_W-1:0] tg);
    logic [TIME_W-1:0] dl;
    expiry_t           e;
    int                pos;
    int                due;
    int                i;
    int                k;
    if (op == MODE_ADD) begin
      dl = sec_count + TIME_W'(dur);
      if (sched_cnt >= DEPTH) begin
        e.status = STATUS_REJECTED;
        e.tg     = tg;
        e.last   = 1'b1;
        expected_expiries.push_back(e);
      end else begin
        pos = 0;
        while (pos < sched_cnt && !is_later(sched_deadline[pos], dl)) pos++;
        for (i = sched_cnt; i > pos; i--) begin
          sched_deadline[i] = sched_deadline[i-1];
          sched_tag[i]      = sched_tag[i-1];
        end
        sched_deadline[pos] = dl;
        sched_tag[pos]      = tg;
        sched_cnt++;
      end
    end else begin
      sec_count = sec_count + 1;
      // due entries form a prefix of the sorted queue
      due = 0;
      while (due < sched_cnt && due < MAX_RESULTS && !is_later(sched_deadline[due], sec_count))
        due++;
      for (k = 0; k < due; k++) begin
        e.status = STATUS_EXPIRED;
        e.tg     = sched_tag[0];
        e.last   = (k == due - 1);
        expected_expiries.push_back(e);
        for (i = 0; i + 1 < sched_cnt; i++) begin
          sched_deadline[i] = sched_deadline[i+1];
          sched_tag[i]      = sched_tag[i+1];
        end
        sched_cnt--;
      end
    end
  endtask

  // driver: a beat stays on the ports until the edge that takes it
  always @(negedge clk) begin : drive
    timer_beat_t nx;
    if (!rst) begin
      if (!start || beat_taken) begin
        beat_taken = 1'b0;
        if (pending_beats.size() > 0 && $urandom_range(99) >= pending_beats[0].idle_pct) begin
          nx = pending_beats.pop_front();
          start    <= 1'b1;
          mode     <= nx.op;
          duration <= nx.dur;
          tag      <= nx.tg;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results are checked before the beat taken at the same edge is predicted
  always @(posedge clk) begin : watch
    expiry_t e;
    if (!rst) begin
      if (strobe) begin
        if (expected_expiries.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0b tag %02h last %0b",
                                    status, out_tag, last));
        end else begin
          e = expected_expiries.pop_front();
          if (status !== e.status)
            report_mismatch($sformatf("status %0b, expected %0b", status, e.status));
          if (out_tag !== e.tg)
            report_mismatch($sformatf("out_tag %02h, expected %02h", out_tag, e.tg));
          if (last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b (tag %02h)", last, e.last, e.tg));
        end
      end
      if (start && !busy) begin
        apply_timer_beat(mode, duration, tag);
        beats_taken++;
        beat_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_deadline_sorted_timer_queue: FAIL");
      $finish;
    end
  end

  initial begin : stim
    int phase_pct[4];
    int directed_n;
    int n_add;
    int n_tick;
    int pct;
    int r;
    int dur;
    int i;
    phase_pct[0] = 0;
    phase_pct[1] = 85;
    phase_pct[2] = 9;
    phase_pct[3] = 0;

    // tick on an empty queue, then two zero-duration timers with extreme tags and a tick that expires both
    queue_beat(MODE_TICK, 0, 0, 0);
    queue_beat(MODE_ADD, 0, 8'h00, 0);
    queue_beat(MODE_ADD, 0, 8'hFF, 0);
    queue_beat(MODE_TICK, 65535, 8'hFF, 0);
    // fill to the top with equal and interleaved deadlines, one far away, then one add that is rejected
    for (i = 0; i < DEPTH - 1; i++)
      queue_beat(MODE_ADD, (i % 3 == 0) ? 2 : 1, 16 + i * 13, 0);
    queue_beat(MODE_ADD, 65535, 8'hA5, 0);
    queue_beat(MODE_ADD, 3, 8'h5A, 0);
    // many expiries on one tick, then the later group
    queue_beat(MODE_TICK, 0, 0, 0);
    queue_beat(MODE_TICK, 0, 0, 0);
    directed_n = beats_total;

    // bursts of adds followed by a few ticks, now and then a noisy mix
    while (beats_total < directed_n + RANDOM_BEATS) begin
      n_add  = $urandom_range(1, 12);
      n_tick = $urandom_range(1, 6);
      for (i = 0; i < n_add + n_tick; i++) begin
        pct = phase_pct[(beats_total - directed_n) * 4 / RANDOM_BEATS > 3 ? 3 :
                        (beats_total - directed_n) * 4 / RANDOM_BEATS];
        r = $urandom_range(99);
        if (r < 5) dur = $urandom_range(65535);
        else if (r < 75) dur = $urandom_range(0, 4);
        else dur = $urandom_range(0, 20);
        if ($urandom_range(9) == 0)
          queue_beat(1'($urandom_range(1)), dur, $urandom_range(255), pct);
        else
          queue_beat(i < n_add ? MODE_ADD : MODE_TICK, dur, $urandom_range(255), pct);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_taken < beats_total || expected_expiries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_expiries.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_expiries.size()));
    if (mismatches == 0) begin
      $display("tb_deadline_sorted_timer_queue: PASS");
    end else begin
      $display("tb_deadline_sorted_timer_queue: FAIL");
    end
    $finish;
  end

endmodule
